FILE: rtl/bsfp_pkg.sv
// package for the buffered serial fifo pair
// holds mode codes, character constants and ring command/status types
// no dependencies
package bsfp_pkg;

   localparam int RX_DEPTH_DEF = 64;
   localparam int TX_DEPTH_DEF = 64;

   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   typedef enum logic [1:0] {
      MODE_LINE_RX  = 2'd0,
      MODE_TX_READY = 2'd1,
      MODE_SW_PUT   = 2'd2,
      MODE_SW_GET   = 2'd3
   } mode_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic [7:0] wr_data;
   } ring_cmd_type;

   typedef struct packed {
      logic empty;
      logic one;
      logic almost_full;
      logic full;
   } ring_stat_type;

endpackage

FILE: rtl/bsfp_req_if.sv
// request channel of the buffered serial fifo pair
// valid/ready handshake carrying mode and data byte; no dependencies
interface bsfp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink (input valid, input mode, input data_byte, output ready);
endinterface

FILE: rtl/bsfp_rsp_if.sv
// response channel of the buffered serial fifo pair
// valid/ready handshake carrying one result word; no dependencies
interface bsfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       line_tx_valid;
   logic [7:0] line_tx_byte;
   logic       read_valid;
   logic [7:0] read_byte;
   logic       put_accepted;
   logic       rx_overflow;
   logic       tx_irq_enable;
   logic       tx_empty;

   modport source (
      output valid, output line_tx_valid, output line_tx_byte, output read_valid,
      output read_byte, output put_accepted, output rx_overflow,
      output tx_irq_enable, output tx_empty, input ready
   );
   modport sink (
      input valid, input line_tx_valid, input line_tx_byte, input read_valid,
      input read_byte, input put_accepted, input rx_overflow,
      input tx_irq_enable, input tx_empty, output ready
   );
endinterface

FILE: rtl/bsfp_ring.sv
// one ring buffer: synchronous byte memory with registered read, plus pointers
// depends on bsfp_pkg for the command and status types
module bsfp_ring import bsfp_pkg::*; #(
   parameter int DEPTH = RX_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  ring_cmd_type  cmd,
   output ring_stat_type stat,
   output logic [7:0]    rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [7:0]    mem_ff [DEPTH];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] wr_slot_ff, wr_slot_in;
   logic          wr_wrap_ff, wr_wrap_in;
   logic [AW-1:0] rd_slot_ff, rd_slot_in;
   logic          rd_wrap_ff, rd_wrap_in;

   always_comb begin
      wr_slot_in = wr_slot_ff;
      wr_wrap_in = wr_wrap_ff;
      if (wr_slot_ff == LAST) begin
         wr_slot_in = '0;
         wr_wrap_in = ~wr_wrap_ff;
      end else begin
         wr_slot_in = wr_slot_ff + AW'(1);
      end
      rd_slot_in = rd_slot_ff;
      rd_wrap_in = rd_wrap_ff;
      if (rd_slot_ff == LAST) begin
         rd_slot_in = '0;
         rd_wrap_in = ~rd_wrap_ff;
      end else begin
         rd_slot_in = rd_slot_ff + AW'(1);
      end
   end

   assign stat.empty       = (wr_slot_ff == rd_slot_ff) && (wr_wrap_ff == rd_wrap_ff);
   assign stat.full        = (wr_slot_ff == rd_slot_ff) && (wr_wrap_ff != rd_wrap_ff);
   assign stat.one         = (rd_slot_in == wr_slot_ff) && (rd_wrap_in == wr_wrap_ff);
   assign stat.almost_full = (wr_slot_in == rd_slot_ff) && (wr_wrap_in != rd_wrap_ff);
   assign rd_data          = rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff <= '0;
         wr_wrap_ff <= 1'b0;
         rd_slot_ff <= '0;
         rd_wrap_ff <= 1'b0;
      end else begin
         if (cmd.push) begin
            wr_slot_ff <= wr_slot_in;
            wr_wrap_ff <= wr_wrap_in;
         end
         if (cmd.pop) begin
            rd_slot_ff <= rd_slot_in;
            rd_wrap_ff <= rd_wrap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem_ff[wr_slot_ff] <= cmd.wr_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem_ff[rd_slot_ff];
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full) else $error("push into full ring");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !stat.empty) else $error("pop from empty ring");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && !cmd.pop && stat.almost_full) |=> stat.full)
      else $error("ring did not report full");
`endif

endmodule

FILE: rtl/bsfp_ctrl.sv
// sequencer for the fifo pair: decodes a request word, drives ring commands,
// builds the response word; depends on bsfp_pkg, bsfp_req_if and bsfp_rsp_if
module bsfp_ctrl import bsfp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   bsfp_req_if.sink      req,
   bsfp_rsp_if.source    rsp,
   output ring_cmd_type  rx_cmd,
   input  ring_stat_type rx_stat,
   input  logic [7:0]    rx_rd_data,
   output ring_cmd_type  tx_cmd,
   input  ring_stat_type tx_stat,
   input  logic [7:0]    tx_rd_data
);

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic       irq_ff, irq_in;
   logic       lf_pend_ff, lf_pend_in;
   logic       txv_ff, txv_in;
   logic       rdv_ff, rdv_in;
   logic       acc_ff, acc_in;
   logic       ovf_ff, ovf_in;
   logic       txe_ff, txe_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_txv_ff, rsp_txv_in;
   logic [7:0] rsp_txb_ff, rsp_txb_in;
   logic       rsp_rdv_ff, rsp_rdv_in;
   logic [7:0] rsp_rdb_ff, rsp_rdb_in;
   logic       rsp_acc_ff, rsp_acc_in;
   logic       rsp_ovf_ff, rsp_ovf_in;
   logic       rsp_irq_ff, rsp_irq_in;
   logic       rsp_txe_ff, rsp_txe_in;

   logic       need_two;
   logic       put_room;

   assign req.ready = (state_ff == ST_IDLE);
   assign need_two  = (req.data_byte == CH_LF);
   assign put_room  = need_two ? (!tx_stat.full && !tx_stat.almost_full) : !tx_stat.full;

   always_comb begin
      state_in     = state_ff;
      irq_in       = irq_ff;
      lf_pend_in   = lf_pend_ff;
      txv_in       = txv_ff;
      rdv_in       = rdv_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      txe_in       = txe_ff;
      rx_cmd       = '0;
      tx_cmd       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_txv_in   = rsp_txv_ff;
      rsp_txb_in   = rsp_txb_ff;
      rsp_rdv_in   = rsp_rdv_ff;
      rsp_rdb_in   = rsp_rdb_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_irq_in   = rsp_irq_ff;
      rsp_txe_in   = rsp_txe_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in   = ST_FINISH;
               txv_in     = 1'b0;
               rdv_in     = 1'b0;
               acc_in     = 1'b0;
               ovf_in     = 1'b0;
               lf_pend_in = 1'b0;
               txe_in     = tx_stat.empty;
               case (mode_type'(req.mode))
                  MODE_LINE_RX: begin
                     if (rx_stat.full) begin
                        ovf_in = 1'b1;
                     end else begin
                        rx_cmd.push    = 1'b1;
                        rx_cmd.wr_data = req.data_byte;
                     end
                  end
                  MODE_TX_READY: begin
                     if (tx_stat.empty) begin
                        irq_in = 1'b0;
                     end else begin
                        tx_cmd.pop = 1'b1;
                        txv_in     = 1'b1;
                        txe_in     = tx_stat.one;
                     end
                  end
                  MODE_SW_PUT: begin
                     if (put_room) begin
                        tx_cmd.push    = 1'b1;
                        tx_cmd.wr_data = need_two ? CH_CR : req.data_byte;
                        lf_pend_in     = need_two;
                        irq_in         = 1'b1;
                        acc_in         = 1'b1;
                        txe_in         = 1'b0;
                     end
                  end
                  MODE_SW_GET: begin
                     if (!rx_stat.empty) begin
                        rx_cmd.pop = 1'b1;
                        rdv_in     = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (lf_pend_ff) begin
               tx_cmd.push    = 1'b1;
               tx_cmd.wr_data = CH_LF;
               lf_pend_in     = 1'b0;
            end
            if (!rsp_valid_ff || rsp.ready) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_txv_in   = txv_ff;
               rsp_txb_in   = txv_ff ? tx_rd_data : 8'h00;
               rsp_rdv_in   = rdv_ff;
               rsp_rdb_in   = rdv_ff ? rx_rd_data : 8'h00;
               rsp_acc_in   = acc_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_irq_in   = irq_ff;
               rsp_txe_in   = txe_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         irq_ff       <= 1'b0;
         lf_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         irq_ff       <= irq_in;
         lf_pend_ff   <= lf_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      txv_ff     <= txv_in;
      rdv_ff     <= rdv_in;
      acc_ff     <= acc_in;
      ovf_ff     <= ovf_in;
      txe_ff     <= txe_in;
      rsp_txv_ff <= rsp_txv_in;
      rsp_txb_ff <= rsp_txb_in;
      rsp_rdv_ff <= rsp_rdv_in;
      rsp_rdb_ff <= rsp_rdb_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_irq_ff <= rsp_irq_in;
      rsp_txe_ff <= rsp_txe_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.line_tx_valid = rsp_txv_ff;
   assign rsp.line_tx_byte  = rsp_txb_ff;
   assign rsp.read_valid    = rsp_rdv_ff;
   assign rsp.read_byte     = rsp_rdb_ff;
   assign rsp.put_accepted  = rsp_acc_ff;
   assign rsp.rx_overflow   = rsp_ovf_ff;
   assign rsp.tx_irq_enable = rsp_irq_ff;
   assign rsp.tx_empty      = rsp_txe_ff;

`ifndef SYNTH
   a_lf_in_finish: assert property (@(posedge clock) disable iff (reset)
      lf_pend_ff |-> (state_ff == ST_FINISH)) else $error("line feed pending outside finish");
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_txv_ff, rsp_rdv_ff, rsp_acc_ff, rsp_ovf_ff}))
      else $error("more than one event flag in a word");
   a_put_sets_irq: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_acc_ff) |-> (rsp_irq_ff && !rsp_txe_ff))
      else $error("accepted put without interrupt enable");
   a_ring_idle_cmd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !lf_pend_ff) |-> !(tx_cmd.push || tx_cmd.pop || rx_cmd.push
      || rx_cmd.pop)) else $error("ring access while finishing");
`endif

endmodule

FILE: rtl/buffered_serial_fifo_pair.sv
// buffered serial fifo pair: receive and transmit byte rings between a line and software
// result word: built in the finish state and held in the output register until taken
// requests: taken only in the idle state; the finish state serves the ring memory read
// and second ring write of a line feed put; output register frees the request side
// reset: synchronous, clears ring pointers, interrupt enable and output valid; ring
// memories are not cleared. depends on bsfp_pkg, bsfp_req_if, bsfp_rsp_if, bsfp_ring, bsfp_ctrl
module buffered_serial_fifo_pair import bsfp_pkg::*; #(
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bsfp_req_if.sink   req_if,
   bsfp_rsp_if.source rsp_if
);

   ring_cmd_type  rx_cmd;
   ring_stat_type rx_stat;
   logic [7:0]    rx_rd_data;
   ring_cmd_type  tx_cmd;
   ring_stat_type tx_stat;
   logic [7:0]    tx_rd_data;

   bsfp_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rx_cmd),
      .stat    (rx_stat),
      .rd_data (rx_rd_data)
   );

   bsfp_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tx_cmd),
      .stat    (tx_stat),
      .rd_data (tx_rd_data)
   );

   bsfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .rx_cmd     (rx_cmd),
      .rx_stat    (rx_stat),
      .rx_rd_data (rx_rd_data),
      .tx_cmd     (tx_cmd),
      .tx_stat    (tx_stat),
      .tx_rd_data (tx_rd_data)
   );

endmodule
